/* rtl/core/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg
// Types, constants and palette functions shared by the colour downgrade block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_RGB   = 2'd2;

    localparam logic [1:0] MODE_TRUE  = 2'd0;
    localparam logic [1:0] MODE_A256  = 2'd1;
    localparam logic [1:0] MODE_A16   = 2'd2;
    localparam logic [1:0] MODE_MONO  = 2'd3;

    localparam int          NUM_CELLS  = 24;
    localparam logic [7:0]  GREY_START = 8'd232;
    localparam logic [7:0]  CUBE_START = 8'd16;
    localparam int          DIST_W     = 18;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // One word travelling down the chain.
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        index;
        rgb_t              color;
        logic              search;
        logic              use_sys;
        logic [DIST_W-1:0] best_dist;
        logic [7:0]        best_idx;
    } pcd_word_t;

    // Candidate held by one cell.
    typedef struct packed {
        rgb_t       sys_rgb;
        logic       sys_en;
        logic [7:0] sys_idx;
        rgb_t       grey_rgb;
        logic [7:0] grey_idx;
    } pcd_cand_t;

    function automatic rgb_t sys_rgb(input logic [3:0] idx);
        rgb_t c;
        case (idx)
            4'd0:    c = '{8'd0,   8'd0,   8'd0};
            4'd1:    c = '{8'd205, 8'd0,   8'd0};
            4'd2:    c = '{8'd0,   8'd205, 8'd0};
            4'd3:    c = '{8'd205, 8'd205, 8'd0};
            4'd4:    c = '{8'd0,   8'd0,   8'd238};
            4'd5:    c = '{8'd205, 8'd0,   8'd205};
            4'd6:    c = '{8'd0,   8'd205, 8'd205};
            4'd7:    c = '{8'd229, 8'd229, 8'd229};
            4'd8:    c = '{8'd127, 8'd127, 8'd127};
            4'd9:    c = '{8'd255, 8'd0,   8'd0};
            4'd10:   c = '{8'd0,   8'd255, 8'd0};
            4'd11:   c = '{8'd255, 8'd255, 8'd0};
            4'd12:   c = '{8'd92,  8'd92,  8'd255};
            4'd13:   c = '{8'd255, 8'd0,   8'd255};
            4'd14:   c = '{8'd0,   8'd255, 8'd255};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] level_of(input logic [2:0] step);
        logic [7:0] v;
        case (step)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd95;
            3'd2:    v = 8'd135;
            3'd3:    v = 8'd175;
            3'd4:    v = 8'd215;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // Nearest cube level, tie to the lower level.
    function automatic logic [2:0] near_step(input logic [7:0] v);
        logic [2:0] s;
        if (v <= 8'd47)
            s = 3'd0;
        else if (v <= 8'd115)
            s = 3'd1;
        else if (v <= 8'd155)
            s = 3'd2;
        else if (v <= 8'd195)
            s = 3'd3;
        else if (v <= 8'd235)
            s = 3'd4;
        else
            s = 3'd5;
        return s;
    endfunction

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic logic [DIST_W-1:0] distance(input rgb_t a, input rgb_t b);
        return DIST_W'(sq_diff(a.r, b.r)) + DIST_W'(sq_diff(a.g, b.g))
             + DIST_W'(sq_diff(a.b, b.b));
    endfunction

    function automatic rgb_t palette_rgb(input logic [7:0] idx);
        rgb_t       c;
        logic [7:0] v;
        logic [7:0] rem;
        logic [2:0] rs;
        logic [2:0] gs;
        logic [2:0] bs;
        logic [7:0] grey;
        v    = idx - CUBE_START;
        rs   = (v >= 8'd180) ? 3'd5 : (v >= 8'd144) ? 3'd4 : (v >= 8'd108) ? 3'd3 :
               (v >= 8'd72)  ? 3'd2 : (v >= 8'd36)  ? 3'd1 : 3'd0;
        rem  = v - 8'(36 * rs);
        gs   = (rem >= 8'd30) ? 3'd5 : (rem >= 8'd24) ? 3'd4 : (rem >= 8'd18) ? 3'd3 :
               (rem >= 8'd12) ? 3'd2 : (rem >= 8'd6)  ? 3'd1 : 3'd0;
        bs   = 3'(rem - 8'(6 * gs));
        grey = 8'(8 + 10 * (idx - GREY_START));
        if (idx < CUBE_START)
            c = sys_rgb(idx[3:0]);
        else if (idx < GREY_START)
            c = '{level_of(rs), level_of(gs), level_of(bs)};
        else
            c = '{grey, grey, grey};
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pcd_head.sv */
// ----------------------------------------------------------------------------
// pcd_head
// Decodes mode and colour kind; in 256-colour mode seeds the search with the nearest cube entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_head
    import pcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] depth_mode,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] color_kind,
    input  wire logic [7:0] color_index,
    input  wire rgb_t       color_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output pcd_word_t       out_word
);

    logic      valid_reg;
    pcd_word_t word_reg;
    pcd_word_t word_next;
    logic [2:0] rs;
    logic [2:0] gs;
    logic [2:0] bs;
    rgb_t       cube_rgb;

    always_comb
    begin
        rs       = near_step(color_in.r);
        gs       = near_step(color_in.g);
        bs       = near_step(color_in.b);
        cube_rgb = '{level_of(rs), level_of(gs), level_of(bs)};
    end

    always_comb
    begin
        word_next           = '0;
        word_next.kind      = KIND_NONE;
        word_next.color     = color_in;
        word_next.best_dist = '1;
        if (color_kind == KIND_INDEX || color_kind == KIND_RGB)
        begin
            case (depth_mode)
                MODE_TRUE:
                begin
                    word_next.kind = color_kind;
                    if (color_kind == KIND_INDEX)
                        word_next.index = color_index;
                end
                MODE_A256:
                begin
                    word_next.kind = KIND_INDEX;
                    if (color_kind == KIND_INDEX)
                        word_next.index = color_index;
                    else
                    begin
                        word_next.search    = 1'b1;
                        word_next.best_idx  = CUBE_START + 8'(36 * rs) + 8'(6 * gs) + 8'(bs);
                        word_next.best_dist = distance(color_in, cube_rgb);
                    end
                end
                MODE_A16:
                begin
                    word_next.kind = KIND_INDEX;
                    if (color_kind == KIND_INDEX && color_index < CUBE_START)
                        word_next.index = color_index;
                    else
                    begin
                        word_next.search  = 1'b1;
                        word_next.use_sys = 1'b1;
                        if (color_kind == KIND_INDEX)
                            word_next.color = palette_rgb(color_index);
                    end
                end
                default:
                begin
                    word_next.kind = KIND_NONE;
                end
            endcase
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

`default_nettype wire

/* rtl/core/pcd_cell.sv */
// ----------------------------------------------------------------------------
// pcd_cell
// One link of the search chain: tests one candidate, keeps the nearer entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_cell
    import pcd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pcd_cand_t cand,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pcd_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output pcd_word_t      out_word
);

    logic              valid_reg;
    pcd_word_t         word_reg;
    pcd_word_t         word_next;
    rgb_t              cand_rgb;
    logic [7:0]        cand_idx;
    logic              active;
    logic [DIST_W-1:0] cand_dist;

    always_comb
    begin
        cand_rgb  = in_word.use_sys ? cand.sys_rgb : cand.grey_rgb;
        cand_idx  = in_word.use_sys ? cand.sys_idx : cand.grey_idx;
        active    = in_word.search && (!in_word.use_sys || cand.sys_en);
        cand_dist = distance(in_word.color, cand_rgb);
        word_next = in_word;
        // strict compare: a tie keeps the lower index already held
        if (active && cand_dist < in_word.best_dist)
        begin
            word_next.best_dist = cand_dist;
            word_next.best_idx  = cand_idx;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

`default_nettype wire

/* rtl/core/palette_color_downgrade.sv */
// Latency from an accepted word to its result is set by the head stage plus 24 cells.
// Throughput: one word per cycle while the result is not stalled; each stage holds
// one word and advances when the next stage is empty or moving, so a stalled result
// does not block upstream bubbles. Each cell of the compare chain tests one candidate.
// Reset: all stage valid flags clear, depth_mode returns to truecolor.
// ----------------------------------------------------------------------------
// palette_color_downgrade
// Converts one colour per word to the configured depth via a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_color_downgrade
    import pcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [1:0] color_kind,
    input  wire logic [7:0] color_index,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_index,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out
);

    logic [1:0] depth_mode_reg;
    logic       stage_valid [NUM_CELLS+1];
    logic       stage_ready [NUM_CELLS+1];
    pcd_word_t  stage_word  [NUM_CELLS+1];
    pcd_word_t  last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_mode_reg <= MODE_TRUE;
        else if (cfg_wr_en)
            depth_mode_reg <= cfg_wr_data;
    end

    pcd_head u_head (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_mode  (depth_mode_reg),
        .in_valid    (item_valid),
        .in_ready    (item_ready),
        .color_kind  (color_kind),
        .color_index (color_index),
        .color_in    ({red_in, green_in, blue_in}),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_word    (stage_word[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        pcd_cand_t cand;

        always_comb
        begin
            cand.sys_rgb  = sys_rgb(4'(k));
            cand.sys_en   = (k < 16);
            cand.sys_idx  = 8'(k);
            cand.grey_rgb = '{8'(8 + 10 * k), 8'(8 + 10 * k), 8'(8 + 10 * k)};
            cand.grey_idx = GREY_START + 8'(k);
        end

        pcd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cand      (cand),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_word   (stage_word[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_word  (stage_word[k+1])
        );
    end

    assign stage_ready[NUM_CELLS] = result_ready;
    assign last_word              = stage_word[NUM_CELLS];
    assign result_valid           = stage_valid[NUM_CELLS];

    always_comb
    begin
        out_kind  = last_word.kind;
        out_index = 8'd0;
        red_out   = 8'd0;
        green_out = 8'd0;
        blue_out  = 8'd0;
        if (last_word.kind == KIND_INDEX)
            out_index = last_word.search ? last_word.best_idx : last_word.index;
        if (last_word.kind == KIND_RGB)
        begin
            red_out   = last_word.color.r;
            green_out = last_word.color.g;
            blue_out  = last_word.color.b;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pcd_checker.sv */
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks on the result channel of the colour downgrade block.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_checker
    import pcd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [1:0] out_kind,
    input wire logic [7:0] out_index,
    input wire logic [7:0] red_out,
    input wire logic [7:0] green_out,
    input wire logic [7:0] blue_out
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_kind)
            && $stable(out_index) && $stable(red_out) && $stable(green_out)
            && $stable(blue_out))
        else $error("result word changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_kind == KIND_NONE || out_kind == KIND_INDEX
            || out_kind == KIND_RGB)
        else $error("undefined result kind");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_kind != KIND_INDEX |-> out_index == 8'd0)
        else $error("index set on non-index result");

    a_rgb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_kind != KIND_RGB
            |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
        else $error("channels set on non-rgb result");

endmodule

bind palette_color_downgrade pcd_checker u_pcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_kind     (out_kind),
    .out_index    (out_index),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out)
);

`default_nettype wire
